// File: sv/multi_slot_software_timer_table_macros.svh
// assertion macros for the timer table
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef MULTI_SLOT_SOFTWARE_TIMER_TABLE_MACROS_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_TABLE_MACROS_SVH

// same-cycle implication
`define MSTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mstt_pkg.sv
// shared types and constants of the timer table
// no dependencies
`default_nettype none

package mstt_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    localparam logic [63:0] IDLE_NAP_RST = 64'd1000000;
    localparam logic [31:0] HW_DELAY_RST = 32'd0;

    // command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_FIRE  = 2'd2;
    localparam logic [1:0] KIND_NAP   = 2'd3;

    // configuration register indexes
    localparam logic CFG_IDLE_NAP = 1'b0;
    localparam logic CFG_HW_DELAY = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic    en;
        t_alu_op op;
    } t_alu_ctl;

    typedef struct packed {
        logic rd;
        logic wr_int;
        logic wr_exp;
        logic wr_id;
    } t_mem_ctl;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_FIND,
        ST_STOP_RD,
        ST_STOP_CMP,
        ST_T_ADD,
        ST_T_SET,
        ST_F_RD,
        ST_F_ARM,
        ST_F_CMP,
        ST_F_DEC,
        ST_F_EMIT,
        ST_F_WR,
        ST_M_RD,
        ST_M_G,
        ST_M_GD,
        ST_M_LT,
        ST_M_LD,
        ST_N_SUB,
        ST_N_SEL,
        ST_N_EMIT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: sv/multi_slot_software_timer_table.sv
// Timer table with a slot sequencer, one shared 64-bit add/subtract unit
// and a one-port slot memory. Depends on mstt_pkg, mstt_alu, mstt_slot_mem.
//
// Input channel (i_in_valid / o_in_ready) carries one command item: start,
// stop or tick. The block takes one item at a time; o_in_ready is high only
// while no item is in work. Results leave through a one-item output register
// (o_out_valid / i_out_ready); o_last marks the final result of an item.
// Work per item:
//   start: free slot search, one slot a cycle
//   stop:  memory read then id compare per slot
//   tick:  a fire pass and a minimum pass over the slots, each enabled slot
//          using the shared adder, which does one 64-bit add or subtract
//          per cycle.
// A result appears in the cycle after it is computed. When the receiver
// stalls, the sequencer waits in front of the full output register and the
// table is left unchanged until the result is taken. Reset empties the table
// (enable bits only, no memory pass), clears the id counter and loads
// idle_nap = 1000000 and hw_delay = 0. Configuration (i_cfg_we, i_cfg_idx,
// i_cfg_data) is written at once; the user must write it only while idle, which the block does not enforce.
`default_nettype none
`include "multi_slot_software_timer_table_macros.svh"

module multi_slot_software_timer_table #(
    parameter int TIMER_SLOTS = mstt_pkg::TIMER_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command items
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [15:0] i_timer_id,
    input  wire logic        i_one_shot,
    input  wire logic [63:0] i_interval_ticks,
    input  wire logic [63:0] i_now_time,
    input  wire logic [63:0] i_proc_time,
    // result items
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [1:0]  o_kind,
    output logic      [15:0] o_result_id,
    output logic             o_accepted,
    output logic      [63:0] o_nap_time,
    output logic             o_last,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);
    import mstt_pkg::*;

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TIMER_SLOTS - 1);

    t_state r_state, n_state;

    // latched command
    logic [15:0] r_id, n_id;
    logic        r_shot, n_shot;
    logic [63:0] r_int, n_int;
    logic [63:0] r_now, n_now;
    logic [63:0] r_proc, n_proc;

    // table control state
    logic [15:0]            r_cnt, n_cnt;
    logic [TIMER_SLOTS-1:0] r_en, n_en;
    logic [TIMER_SLOTS-1:0] r_os, n_os;
    logic [AW-1:0]          r_idx, n_idx;

    // scan working registers
    logic [63:0] r_exp, n_exp;
    logic [63:0] r_guard, n_guard;
    logic [63:0] r_nap, n_nap;
    logic [63:0] r_left, n_left;
    logic [1:0]  r_res_kind, n_res_kind;
    logic [15:0] r_res_id, n_res_id;
    logic        r_res_acc, n_res_acc;

    // configuration registers
    logic [63:0] r_idle_nap;
    logic [31:0] r_hw_delay;

    // output register
    logic        r_ov;
    logic [1:0]  r_o_kind;
    logic [15:0] r_o_id;
    logic        r_o_acc;
    logic [63:0] r_o_nap;
    logic        r_o_last;

    // datapath controls
    t_alu_ctl    w_alu_ctl;
    logic [63:0] w_alu_a, w_alu_b, w_alu_res;
    logic        w_alu_borrow;
    t_mem_ctl    w_mem_ctl;
    logic [63:0] w_wr_exp;
    logic [63:0] w_rd_int, w_rd_exp;
    logic [15:0] w_rd_id;

    logic        w_emit;
    logic [1:0]  w_e_kind;
    logic [15:0] w_e_id;
    logic        w_e_acc;
    logic [63:0] w_e_nap;
    logic        w_e_last;

    logic          w_out_free;
    logic          w_accept;
    logic          w_is_last;
    logic [AW-1:0] w_nxt_idx;
    logic [15:0]   w_cnt_inc;
    logic [63:0]   w_exp_cur;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_ov || i_out_ready;
    assign w_is_last  = (r_idx == LAST_IDX);
    assign w_nxt_idx  = w_is_last ? '0 : r_idx + AW'(1);
    assign w_cnt_inc  = r_cnt + 16'd1;
    assign w_exp_cur  = (w_rd_exp == 64'd0) ? w_alu_res : w_rd_exp;

    mstt_alu u_alu (
        .i_clk    (i_clk),
        .i_ctl    (w_alu_ctl),
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .o_res    (w_alu_res),
        .o_borrow (w_alu_borrow)
    );

    mstt_slot_mem #(
        .SLOTS (TIMER_SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_ctl  (w_mem_ctl),
        .i_addr (r_idx),
        .i_int  (r_int),
        .i_exp  (w_wr_exp),
        .i_id   (r_id),
        .o_int  (w_rd_int),
        .o_exp  (w_rd_exp),
        .o_id   (w_rd_id)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_cmd)
                        CMD_START: n_state = ST_START;
                        CMD_STOP:  n_state = (i_timer_id == 16'd0) ? ST_DONE : ST_STOP_RD;
                        CMD_TICK:  n_state = ST_T_ADD;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_START: n_state = ST_FIND;
            ST_FIND: begin
                if (!r_en[r_idx] || w_is_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_STOP_RD: begin
                if (r_en[r_idx]) begin
                    n_state = ST_STOP_CMP;
                end else if (w_is_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_STOP_CMP: begin
                if (w_rd_id == r_id || w_is_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_STOP_RD;
                end
            end
            ST_T_ADD: n_state = ST_T_SET;
            ST_T_SET: n_state = ST_F_RD;
            ST_F_RD: begin
                if (r_en[r_idx]) begin
                    n_state = ST_F_ARM;
                end else if (w_is_last) begin
                    n_state = ST_M_RD;
                end
            end
            ST_F_ARM: n_state = ST_F_CMP;
            ST_F_CMP: n_state = ST_F_DEC;
            ST_F_DEC: begin
                if (!w_alu_borrow) begin
                    n_state = ST_F_EMIT;
                end else begin
                    n_state = w_is_last ? ST_M_RD : ST_F_RD;
                end
            end
            ST_F_EMIT: begin
                if (w_out_free) begin
                    if (!r_os[r_idx]) begin
                        n_state = ST_F_WR;
                    end else begin
                        n_state = w_is_last ? ST_M_RD : ST_F_RD;
                    end
                end
            end
            ST_F_WR: n_state = w_is_last ? ST_M_RD : ST_F_RD;
            ST_M_RD: begin
                if (r_en[r_idx]) begin
                    n_state = ST_M_G;
                end else if (w_is_last) begin
                    n_state = ST_N_SUB;
                end
            end
            ST_M_G:  n_state = ST_M_GD;
            ST_M_GD: n_state = w_alu_borrow ? ST_M_LT : ST_N_SUB;
            ST_M_LT: n_state = ST_M_LD;
            ST_M_LD: n_state = w_is_last ? ST_N_SUB : ST_M_RD;
            ST_N_SUB: n_state = ST_N_SEL;
            ST_N_SEL: n_state = ST_N_EMIT;
            ST_N_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath controls and register updates
    always_comb begin
        n_id       = r_id;
        n_shot     = r_shot;
        n_int      = r_int;
        n_now      = r_now;
        n_proc     = r_proc;
        n_cnt      = r_cnt;
        n_en       = r_en;
        n_os       = r_os;
        n_idx      = r_idx;
        n_exp      = r_exp;
        n_guard    = r_guard;
        n_nap      = r_nap;
        n_left     = r_left;
        n_res_kind = r_res_kind;
        n_res_id   = r_res_id;
        n_res_acc  = r_res_acc;
        w_alu_ctl  = '{en: 1'b0, op: ALU_ADD};
        w_alu_a    = r_now;
        w_alu_b    = w_rd_int;
        w_mem_ctl  = '0;
        w_wr_exp   = r_exp;
        w_emit     = 1'b0;
        w_e_kind   = r_res_kind;
        w_e_id     = r_res_id;
        w_e_acc    = r_res_acc;
        w_e_nap    = 64'd0;
        w_e_last   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_id       = i_timer_id;
                    n_shot     = i_one_shot;
                    n_int      = i_interval_ticks;
                    n_now      = i_now_time;
                    n_proc     = i_proc_time;
                    n_idx      = '0;
                    n_res_kind = (i_cmd == CMD_STOP) ? KIND_STOP : KIND_START;
                    n_res_id   = 16'd0;
                    n_res_acc  = 1'b0;
                end
            end
            // automatic id, counter skips zero
            ST_START: begin
                if (r_id == 16'd0) begin
                    n_cnt = (w_cnt_inc == 16'd0) ? 16'd1 : w_cnt_inc;
                    n_id  = (w_cnt_inc == 16'd0) ? 16'd1 : w_cnt_inc;
                end
            end
            // first free slot takes the timer
            ST_FIND: begin
                if (!r_en[r_idx]) begin
                    w_mem_ctl.wr_int = 1'b1;
                    w_mem_ctl.wr_exp = 1'b1;
                    w_mem_ctl.wr_id  = 1'b1;
                    w_wr_exp         = 64'd0;
                    n_en[r_idx]      = 1'b1;
                    n_os[r_idx]      = r_shot;
                    n_res_id         = r_id;
                    n_res_acc        = 1'b1;
                end else begin
                    n_idx = w_nxt_idx;
                end
            end
            ST_STOP_RD: begin
                if (r_en[r_idx]) begin
                    w_mem_ctl.rd = 1'b1;
                end else begin
                    n_idx = w_nxt_idx;
                end
            end
            ST_STOP_CMP: begin
                if (w_rd_id == r_id) begin
                    n_en[r_idx] = 1'b0;
                    n_res_id    = r_id;
                    n_res_acc   = 1'b1;
                end else begin
                    n_idx = w_nxt_idx;
                end
            end
            // guard = now + hw_delay
            ST_T_ADD: begin
                w_alu_ctl = '{en: 1'b1, op: ALU_ADD};
                w_alu_a   = r_now;
                w_alu_b   = {32'd0, r_hw_delay};
            end
            ST_T_SET: begin
                n_guard = w_alu_res;
                n_nap   = r_idle_nap;
            end
            // fire pass
            ST_F_RD: begin
                if (r_en[r_idx]) begin
                    w_mem_ctl.rd = 1'b1;
                end else begin
                    n_idx = w_nxt_idx;
                end
            end
            ST_F_ARM: begin
                w_alu_ctl = '{en: 1'b1, op: ALU_ADD};
                w_alu_a   = r_now;
                w_alu_b   = w_rd_int;
            end
            ST_F_CMP: begin
                n_exp     = w_exp_cur;
                w_alu_ctl = '{en: 1'b1, op: ALU_SUB};
                w_alu_a   = r_now;
                w_alu_b   = w_exp_cur;
            end
            ST_F_DEC: begin
                if (w_alu_borrow) begin
                    w_mem_ctl.wr_exp = (w_rd_exp == 64'd0);
                    w_wr_exp         = r_exp;
                    n_idx            = w_nxt_idx;
                end
            end
            ST_F_EMIT: begin
                if (w_out_free) begin
                    w_emit   = 1'b1;
                    w_e_kind = KIND_FIRE;
                    w_e_id   = w_rd_id;
                    w_e_acc  = 1'b1;
                    w_e_last = 1'b0;
                    if (r_os[r_idx]) begin
                        n_en[r_idx] = 1'b0;
                        n_idx       = w_nxt_idx;
                    end else begin
                        w_alu_ctl = '{en: 1'b1, op: ALU_ADD};
                        w_alu_a   = r_exp;
                        w_alu_b   = w_rd_int;
                    end
                end
            end
            ST_F_WR: begin
                w_mem_ctl.wr_exp = 1'b1;
                w_wr_exp         = w_alu_res;
                n_idx            = w_nxt_idx;
            end
            // minimum pass
            ST_M_RD: begin
                if (r_en[r_idx]) begin
                    w_mem_ctl.rd = 1'b1;
                end else begin
                    n_idx = w_nxt_idx;
                end
            end
            ST_M_G: begin
                w_alu_ctl = '{en: 1'b1, op: ALU_SUB};
                w_alu_a   = r_guard;
                w_alu_b   = w_rd_exp;
            end
            ST_M_GD: begin
                if (!w_alu_borrow) begin
                    n_nap = 64'd1;
                end else begin
                    w_alu_ctl = '{en: 1'b1, op: ALU_SUB};
                    w_alu_a   = w_rd_exp;
                    w_alu_b   = r_now;
                end
            end
            ST_M_LT: begin
                n_left    = w_alu_res;
                w_alu_ctl = '{en: 1'b1, op: ALU_SUB};
                w_alu_a   = w_alu_res;
                w_alu_b   = r_nap;
            end
            ST_M_LD: begin
                if (w_alu_borrow) begin
                    n_nap = r_left;
                end
                n_idx = w_nxt_idx;
            end
            // processing time off the nap, floor of one
            ST_N_SUB: begin
                w_alu_ctl = '{en: 1'b1, op: ALU_SUB};
                w_alu_a   = r_nap;
                w_alu_b   = r_proc;
            end
            ST_N_SEL: begin
                if (r_nap > 64'd1) begin
                    n_nap = (!w_alu_borrow && w_alu_res != 64'd0) ? w_alu_res : 64'd1;
                end
            end
            ST_N_EMIT: begin
                if (w_out_free) begin
                    w_emit   = 1'b1;
                    w_e_kind = KIND_NAP;
                    w_e_id   = 16'd0;
                    w_e_acc  = 1'b1;
                    w_e_nap  = r_nap;
                end
            end
            ST_DONE: begin
                w_emit = w_out_free;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 16'd0;
            r_en    <= '0;
            r_os    <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_en    <= n_en;
            r_os    <= n_os;
            r_idx   <= n_idx;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_id       <= n_id;
        r_shot     <= n_shot;
        r_int      <= n_int;
        r_now      <= n_now;
        r_proc     <= n_proc;
        r_exp      <= n_exp;
        r_guard    <= n_guard;
        r_nap      <= n_nap;
        r_left     <= n_left;
        r_res_kind <= n_res_kind;
        r_res_id   <= n_res_id;
        r_res_acc  <= n_res_acc;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_nap <= IDLE_NAP_RST;
            r_hw_delay <= HW_DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDLE_NAP: r_idle_nap <= i_cfg_data;
                CFG_HW_DELAY: r_hw_delay <= i_cfg_data[31:0];
                default:      r_idle_nap <= r_idle_nap;
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_kind <= w_e_kind;
            r_o_id   <= w_e_id;
            r_o_acc  <= w_e_acc;
            r_o_nap  <= w_e_nap;
            r_o_last <= w_e_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_kind      = r_o_kind;
    assign o_result_id = r_o_id;
    assign o_accepted  = r_o_acc;
    assign o_nap_time  = r_o_nap;
    assign o_last      = r_o_last;

    // checks
    `MSTT_ASSERT_IMP(a_emit_no_overwrite, w_emit, !r_ov || i_out_ready, "result item overwritten")
    `MSTT_ASSERT_IMP(a_fire_not_last, r_ov && r_o_kind == KIND_FIRE, !r_o_last, "fire marked last")
    `MSTT_ASSERT_IMP(a_nap_is_last, r_ov && r_o_kind == KIND_NAP, r_o_last, "nap not last")
    `MSTT_ASSERT_NXT(a_busy_after_accept, w_accept && i_cmd <= CMD_TICK, !o_in_ready, "not busy")

endmodule

`default_nettype wire

// File: sv/mstt_alu.sv
// shared 64-bit add / subtract unit with registered result and borrow
// depends on mstt_pkg
`default_nettype none

module mstt_alu (
    input  wire logic               i_clk,
    input  wire mstt_pkg::t_alu_ctl i_ctl,
    input  wire logic [63:0]        i_a,
    input  wire logic [63:0]        i_b,
    output logic      [63:0]        o_res,
    output logic                    o_borrow
);
    import mstt_pkg::*;

    logic [64:0] w_sum;
    logic [63:0] r_res;
    logic        r_borrow;

    // top bit is carry on add, borrow (a < b) on subtract
    always_comb begin
        if (i_ctl.op == ALU_ADD) begin
            w_sum = {1'b0, i_a} + {1'b0, i_b};
        end else begin
            w_sum = {1'b0, i_a} - {1'b0, i_b};
        end
    end

    // result register, held until the next operation
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_res    <= w_sum[63:0];
            r_borrow <= w_sum[64];
        end
    end

    assign o_res    = r_res;
    assign o_borrow = r_borrow;

endmodule

`default_nettype wire

// File: sv/mstt_slot_mem.sv
// slot memory: interval, expiry and id per slot, one port, registered read
// depends on mstt_pkg
`default_nettype none

module mstt_slot_mem #(
    parameter int SLOTS = mstt_pkg::TIMER_SLOTS_DEF,
    parameter int AW    = 4
) (
    input  wire logic               i_clk,
    input  wire mstt_pkg::t_mem_ctl i_ctl,
    input  wire logic [AW-1:0]      i_addr,
    input  wire logic [63:0]        i_int,
    input  wire logic [63:0]        i_exp,
    input  wire logic [15:0]        i_id,
    output logic      [63:0]        o_int,
    output logic      [63:0]        o_exp,
    output logic      [15:0]        o_id
);
    import mstt_pkg::*;

    logic [63:0] r_int_mem [SLOTS];
    logic [63:0] r_exp_mem [SLOTS];
    logic [15:0] r_id_mem  [SLOTS];

    logic [63:0] r_int;
    logic [63:0] r_exp;
    logic [15:0] r_id;

    // writes
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_int) begin
            r_int_mem[i_addr] <= i_int;
        end
        if (i_ctl.wr_exp) begin
            r_exp_mem[i_addr] <= i_exp;
        end
        if (i_ctl.wr_id) begin
            r_id_mem[i_addr] <= i_id;
        end
    end

    // read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_int <= r_int_mem[i_addr];
            r_exp <= r_exp_mem[i_addr];
            r_id  <= r_id_mem[i_addr];
        end
    end

    assign o_int = r_int;
    assign o_exp = r_exp;
    assign o_id  = r_id;

endmodule

`default_nettype wire
